### src/hvs_pkg.sv
// Shared constants, widths, register indexes and the arctangent table
// of the haversine distance and bearing core. No dependencies.
package hvs_pkg;

    localparam int CORDIC_STEPS = 30;

    // Q.30 constants of the datapath.
    localparam logic [35:0] Q30_ONE     = 36'd1073741824;
    localparam logic [35:0] Q30_PI      = 36'd3373259426;
    localparam logic [35:0] Q30_HALF_PI = 36'd1686629713;
    localparam logic [35:0] Q30_TWO_PI  = 36'd6746518852;
    localparam logic [35:0] CORDIC_GAIN = 36'd652032874;

    localparam logic [30:0] DIST_MAX        = 31'd1311703040;
    localparam logic [30:0] ANGLE_MAX       = 31'd843314857;
    localparam logic [13:0] EARTH_RADIUS_KM = 14'd6371;

    // Widths of sine/cosine results, arctangent inputs and angle results.
    localparam int SC_W = 32;
    localparam int AT_IN_W = 33;
    localparam int AT_Z_W = 34;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_LAT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_LON = 2'd1;

    // atan(2^-i) in Q.30 radians.
    function automatic logic [31:0] atan_q30(input int unsigned idx);
        logic [31:0] val;
        case (idx)
            0:       val = 32'd843314857;
            1:       val = 32'd497837829;
            2:       val = 32'd263043837;
            3:       val = 32'd133525159;
            4:       val = 32'd67021687;
            5:       val = 32'd33543516;
            6:       val = 32'd16775851;
            7:       val = 32'd8388437;
            8:       val = 32'd4194283;
            9:       val = 32'd2097149;
            10:      val = 32'd1048576;
            11:      val = 32'd524288;
            12:      val = 32'd262144;
            13:      val = 32'd131072;
            14:      val = 32'd65536;
            15:      val = 32'd32768;
            16:      val = 32'd16384;
            17:      val = 32'd8192;
            18:      val = 32'd4096;
            19:      val = 32'd2048;
            20:      val = 32'd1024;
            21:      val = 32'd512;
            22:      val = 32'd256;
            23:      val = 32'd128;
            24:      val = 32'd64;
            25:      val = 32'd32;
            26:      val = 32'd16;
            27:      val = 32'd8;
            28:      val = 32'd4;
            29:      val = 32'd2;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

endpackage

### src/hvs_delay.sv
// Fixed-depth delay line used to keep side data and valid bits in step
// with the CORDIC and square-root pipelines. No package dependencies.
module hvs_delay #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] tap_reg [D];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < D; k++)
            begin
                tap_reg[k] <= '0;
            end
        end
        else
        begin
            tap_reg[0] <= d;
            for (int k = 1; k < D; k++)
            begin
                tap_reg[k] <= tap_reg[k-1];
            end
        end
    end

    assign q = tap_reg[D-1];

endmodule

### src/hvs_sincos.sv
// Pipelined sine and cosine: modulo-2*pi reduction one quotient bit per
// stage, quadrant fold, then one rotation CORDIC step per stage. Uses hvs_pkg.
module hvs_sincos #(
    parameter int TW = 35
) (
    input  logic                            clk,
    input  logic signed [TW-1:0]            theta,
    output logic signed [hvs_pkg::SC_W-1:0] sin_val,
    output logic signed [hvs_pkg::SC_W-1:0] cos_val
);
    import hvs_pkg::*;

    localparam int NR = TW - 32;
    localparam int RW = 35;
    localparam int XW = 34;
    localparam logic signed [RW-1:0] PI_S      = RW'(Q30_PI);
    localparam logic signed [RW-1:0] HALF_PI_S = RW'(Q30_HALF_PI);
    localparam logic signed [RW-1:0] TWO_PI_S  = RW'(Q30_TWO_PI);
    localparam logic signed [XW-1:0] GAIN_S    = XW'(CORDIC_GAIN);

    function automatic logic [TW:0] red_const(input int k);
        return (TW+1)'(Q30_TWO_PI) << (NR - 1 - k);
    endfunction

    logic          neg_reg [NR+1];
    logic [TW-1:0] mag_reg [NR+1];

    logic signed [RW-1:0] r_abs;
    logic signed [RW-1:0] r_signed;
    logic signed [RW-1:0] fold_reg;

    logic signed [XW-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [XW-1:0] y_reg [CORDIC_STEPS+1];
    logic signed [RW-1:0] z_reg [CORDIC_STEPS+1];
    logic                 flip_reg [CORDIC_STEPS+1];

    // The remainder keeps the sign of the dividend, so reduce the magnitude.
    always_ff @(posedge clk)
    begin
        neg_reg[0] <= theta[TW-1];
        mag_reg[0] <= theta[TW-1] ? unsigned'(-theta) : unsigned'(theta);
        for (int k = 0; k < NR; k++)
        begin
            neg_reg[k+1] <= neg_reg[k];
            if ({1'b0, mag_reg[k]} >= red_const(k))
            begin
                mag_reg[k+1] <= TW'({1'b0, mag_reg[k]} - red_const(k));
            end
            else
            begin
                mag_reg[k+1] <= mag_reg[k];
            end
        end
    end

    assign r_abs    = signed'(RW'(mag_reg[NR]));
    assign r_signed = neg_reg[NR] ? -r_abs : r_abs;

    always_ff @(posedge clk)
    begin
        if (r_signed > PI_S)
        begin
            fold_reg <= r_signed - TWO_PI_S;
        end
        else if (r_signed < -PI_S)
        begin
            fold_reg <= r_signed + TWO_PI_S;
        end
        else
        begin
            fold_reg <= r_signed;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0] <= GAIN_S;
        y_reg[0] <= '0;
        if (fold_reg > HALF_PI_S)
        begin
            z_reg[0]    <= fold_reg - PI_S;
            flip_reg[0] <= 1'b1;
        end
        else if (fold_reg < -HALF_PI_S)
        begin
            z_reg[0]    <= fold_reg + PI_S;
            flip_reg[0] <= 1'b1;
        end
        else
        begin
            z_reg[0]    <= fold_reg;
            flip_reg[0] <= 1'b0;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            flip_reg[i+1] <= flip_reg[i];
            if (z_reg[i] >= 0)
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - signed'(RW'(atan_q30(i)));
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + signed'(RW'(atan_q30(i)));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (flip_reg[CORDIC_STEPS])
        begin
            sin_val <= SC_W'(-y_reg[CORDIC_STEPS]);
            cos_val <= SC_W'(-x_reg[CORDIC_STEPS]);
        end
        else
        begin
            sin_val <= SC_W'(y_reg[CORDIC_STEPS]);
            cos_val <= SC_W'(x_reg[CORDIC_STEPS]);
        end
    end

endmodule

### src/hvs_atan2.sv
// Pipelined four-quadrant arctangent: a half-plane pre-rotation, then one
// vectoring CORDIC step per stage. Uses hvs_pkg.
module hvs_atan2 (
    input  logic                               clk,
    input  logic signed [hvs_pkg::AT_IN_W-1:0] y_in,
    input  logic signed [hvs_pkg::AT_IN_W-1:0] x_in,
    output logic signed [hvs_pkg::AT_Z_W-1:0]  z_out
);
    import hvs_pkg::*;

    localparam int AW = 35;
    localparam logic signed [AW-1:0] HALF_PI_S = AW'(Q30_HALF_PI);

    logic signed [AW-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [AW-1:0] y_reg [CORDIC_STEPS+1];
    logic signed [AW-1:0] z_reg [CORDIC_STEPS+1];
    logic                 zero_reg [CORDIC_STEPS+1];

    always_ff @(posedge clk)
    begin
        zero_reg[0] <= (x_in == 0) && (y_in == 0);
        if (x_in < 0)
        begin
            if (y_in >= 0)
            begin
                x_reg[0] <= AW'(y_in);
                y_reg[0] <= -AW'(x_in);
                z_reg[0] <= HALF_PI_S;
            end
            else
            begin
                x_reg[0] <= -AW'(y_in);
                y_reg[0] <= AW'(x_in);
                z_reg[0] <= -HALF_PI_S;
            end
        end
        else
        begin
            x_reg[0] <= AW'(x_in);
            y_reg[0] <= AW'(y_in);
            z_reg[0] <= '0;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            zero_reg[i+1] <= zero_reg[i];
            if (y_reg[i] >= 0)
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + signed'(AW'(atan_q30(i)));
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - signed'(AW'(atan_q30(i)));
            end
        end
        z_out <= zero_reg[CORDIC_STEPS] ? '0 : AT_Z_W'(z_reg[CORDIC_STEPS]);
    end

endmodule

### src/hvs_isqrt.sv
// Pipelined floor square root of a 61-bit value, one result bit per stage.
// No package dependencies.
module hvs_isqrt (
    input  logic        clk,
    input  logic [60:0] radicand,
    output logic [30:0] root
);

    localparam int NB = 31;

    logic [60:0] rem_reg  [NB];
    logic [30:0] root_reg [NB];
    logic [60:0] rem_in   [NB];
    logic [30:0] root_in  [NB];
    logic [62:0] trial    [NB];

    always_comb
    begin
        for (int k = 0; k < NB; k++)
        begin
            rem_in[k]  = (k == 0) ? radicand : rem_reg[(k == 0) ? 0 : k - 1];
            root_in[k] = (k == 0) ? '0 : root_reg[(k == 0) ? 0 : k - 1];
            trial[k]   = (63'(root_in[k]) << (NB - k)) + (63'(1) << (2 * (NB - 1 - k)));
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NB; k++)
        begin
            if (63'(rem_in[k]) >= trial[k])
            begin
                rem_reg[k]  <= 61'(63'(rem_in[k]) - trial[k]);
                root_reg[k] <= root_in[k] | (31'(1) << (NB - 1 - k));
            end
            else
            begin
                rem_reg[k]  <= rem_in[k];
                root_reg[k] <= root_in[k];
            end
        end
    end

    assign root = root_reg[NB-1];

endmodule

### src/haversine_distance_and_bearing_core.sv
// Top level of the haversine great-circle distance and bearing core.
// Depends on hvs_pkg, hvs_sincos, hvs_atan2, hvs_isqrt and hvs_delay.
//
//  Channel   Handshake            Payload
//  -------   ------------------   ------------------------------------------
//  input     start / busy         point_lat, point_lon
//  result    done (one cycle)     distance, azimuth, plane_angle,
//                                 offset_first, offset_second
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// The datapath is a pipeline whose depth is set by the two chained
// sine/cosine CORDICs (their angle width TW = 63 - ANGLE_FRAC_BITS), the
// square-root stage and the arctangent CORDIC. A new item is accepted in
// every cycle, so busy stays low. Reset clears the origin registers and
// the valid bits; items in flight are dropped. The receiver cannot stall:
// each result appears for exactly one cycle with done high.
module haversine_distance_and_bearing_core #(
    parameter int ANGLE_FRAC_BITS = 28,
    parameter int DIST_FRAC_BITS  = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [29:0]                 point_lat,
    input  logic signed [30:0]                 point_lon,
    output logic                               done,
    output logic [30:0]                        distance,
    output logic signed [30:0]                 azimuth,
    output logic signed [30:0]                 plane_angle,
    output logic signed [31:0]                 offset_first,
    output logic signed [31:0]                 offset_second,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hvs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [31:0]                        cfg_data
);
    import hvs_pkg::*;

    // Shift that brings input angles to Q.30, and the angle width that
    // the widest difference of two shifted longitudes needs.
    localparam int AS   = 30 - ANGLE_FRAC_BITS;
    localparam int TW   = 33 + AS;
    localparam int DS   = 30 - DIST_FRAC_BITS;
    localparam int LSC  = TW + 2;
    localparam int LSQ  = 31;
    localparam int LTOT = 2 * LSC + 72;
    localparam int MW   = 34;

    localparam logic signed [48:0] RND_D = 49'(1) << (DS - 1);
    localparam logic signed [34:0] RND_A = (AS == 0) ? 35'(0) : 35'(1) << (AS - 1);
    localparam logic signed [48:0] DMAX_49  = 49'(DIST_MAX);
    localparam logic signed [34:0] AMAX_35  = 35'(ANGLE_MAX);
    localparam logic signed [33:0] OMAX_34  = 34'(DIST_MAX);

    // Product of two Q.30 values, floored back to Q.30.
    function automatic logic signed [MW-1:0] qmul(input logic signed [MW-1:0] a,
                                                  input logic signed [MW-1:0] b);
        logic signed [2*MW-1:0] p;
        p = (2*MW)'(a) * (2*MW)'(b);
        return MW'(p >>> 30);
    endfunction

    function automatic logic signed [30:0] sat_angle(input logic signed [34:0] v);
        logic signed [30:0] r;
        if (v > AMAX_35)
            r = 31'(AMAX_35);
        else if (v < -AMAX_35)
            r = 31'(-AMAX_35);
        else
            r = 31'(v);
        return r;
    endfunction

    function automatic logic signed [31:0] sat_offset(input logic signed [63:0] p);
        logic signed [33:0] v;
        logic signed [31:0] r;
        v = 34'((p + 64'(1 << 29)) >>> 30);
        if (v > OMAX_34)
            r = 32'(OMAX_34);
        else if (v < -OMAX_34)
            r = 32'(-OMAX_34);
        else
            r = 32'(v);
        return r;
    endfunction

    logic accept;
    logic signed [29:0] origin_lat_reg;
    logic signed [30:0] origin_lon_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start & ~busy;

    // Writes to indexes beyond the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_lat_reg <= '0;
            origin_lon_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ORIGIN_LAT: origin_lat_reg <= signed'(cfg_data[29:0]);
                REG_ORIGIN_LON: origin_lon_reg <= signed'(cfg_data[30:0]);
                default:        ;
            endcase
        end
    end

    // Stage 0: scale to Q.30 and form the five angles the trigonometry needs.
    logic signed [TW-1:0] lat1, lat2, lon1, lon2, dlat, dlon;
    logic signed [TW-1:0] th_p1_reg, th_p2_reg, th_dlon_reg, th_hlat_reg, th_hlon_reg;

    assign lat1 = TW'(origin_lat_reg);
    assign lat2 = TW'(point_lat);
    assign lon1 = TW'(origin_lon_reg);
    assign lon2 = TW'(point_lon);
    assign dlat = (lat2 - lat1) <<< AS;
    assign dlon = (lon2 - lon1) <<< AS;

    always_ff @(posedge clk)
    begin
        th_p1_reg   <= lat1 <<< AS;
        th_p2_reg   <= lat2 <<< AS;
        th_dlon_reg <= dlon;
        th_hlat_reg <= dlat >>> 1;
        th_hlon_reg <= dlon >>> 1;
    end

    logic signed [SC_W-1:0] s1, c1, s2, c2, sd, cd, shl, shd;

    hvs_sincos #(.TW(TW)) u_sc_p1 (.clk(clk), .theta(th_p1_reg), .sin_val(s1), .cos_val(c1));
    hvs_sincos #(.TW(TW)) u_sc_p2 (.clk(clk), .theta(th_p2_reg), .sin_val(s2), .cos_val(c2));
    hvs_sincos #(.TW(TW)) u_sc_dl (.clk(clk), .theta(th_dlon_reg), .sin_val(sd), .cos_val(cd));
    hvs_sincos #(.TW(TW)) u_sc_hlat (.clk(clk), .theta(th_hlat_reg), .sin_val(shl),
                                     .cos_val());
    hvs_sincos #(.TW(TW)) u_sc_hlon (.clk(clk), .theta(th_hlon_reg), .sin_val(shd),
                                     .cos_val());

    // Three product stages build the haversine sum and the plane terms.
    logic signed [MW-1:0] m1_hl_reg, m1_hd_reg, m1_east_reg, m1_t1_reg, m1_t2_reg;
    logic signed [MW-1:0] m1_c1_reg, m1_c2_reg, m1_cd_reg;
    logic signed [MW-1:0] m2_hl_reg, m2_m_reg, m2_t3_reg, m2_c2_reg, m2_t1_reg, m2_east_reg;
    logic signed [MW-1:0] m3_hl_reg, m3_m2_reg, m3_east_reg;
    logic signed [MW:0]   m3_north_reg;

    always_ff @(posedge clk)
    begin
        m1_hl_reg   <= qmul(MW'(shl), MW'(shl));
        m1_hd_reg   <= qmul(MW'(shd), MW'(shd));
        m1_east_reg <= qmul(MW'(sd), MW'(c2));
        m1_t1_reg   <= qmul(MW'(c1), MW'(s2));
        m1_t2_reg   <= qmul(MW'(s1), MW'(c2));
        m1_c1_reg   <= MW'(c1);
        m1_c2_reg   <= MW'(c2);
        m1_cd_reg   <= MW'(cd);

        m2_m_reg    <= qmul(m1_hd_reg, m1_c1_reg);
        m2_t3_reg   <= qmul(m1_t2_reg, m1_cd_reg);
        m2_hl_reg   <= m1_hl_reg;
        m2_c2_reg   <= m1_c2_reg;
        m2_t1_reg   <= m1_t1_reg;
        m2_east_reg <= m1_east_reg;

        m3_m2_reg    <= qmul(m2_m_reg, m2_c2_reg);
        m3_north_reg <= (MW+1)'(m2_t1_reg) - (MW+1)'(m2_t3_reg);
        m3_hl_reg    <= m2_hl_reg;
        m3_east_reg  <= m2_east_reg;
    end

    // Clamp the haversine sum to [0, 1] and form both square-root operands.
    logic signed [MW:0]         a_sum;
    logic [30:0]                a_clip;
    logic [60:0]                va_reg, vb_reg;
    logic signed [AT_IN_W-1:0]  east4_reg, north4_reg;

    assign a_sum = (MW+1)'(m3_hl_reg) + (MW+1)'(m3_m2_reg);

    always_comb
    begin
        if (a_sum < 0)
            a_clip = '0;
        else if (a_sum > (MW+1)'(Q30_ONE))
            a_clip = 31'(Q30_ONE);
        else
            a_clip = 31'(a_sum);
    end

    always_ff @(posedge clk)
    begin
        va_reg     <= {a_clip, 30'd0};
        vb_reg     <= {31'(Q30_ONE) - a_clip, 30'd0};
        east4_reg  <= AT_IN_W'(m3_east_reg);
        north4_reg <= AT_IN_W'(m3_north_reg);
    end

    logic [30:0] root_a, root_b;

    hvs_isqrt u_sq_a (.clk(clk), .radicand(va_reg), .root(root_a));
    hvs_isqrt u_sq_b (.clk(clk), .radicand(vb_reg), .root(root_b));

    // Plane terms wait out the square roots so that all three arctangents line up.
    logic [2*AT_IN_W-1:0]      en_dly;
    logic signed [AT_IN_W-1:0] east_d, north_d;

    hvs_delay #(.W(2 * AT_IN_W), .D(LSQ)) u_dly_en (
        .clk(clk), .rst_n(rst_n), .d({east4_reg, north4_reg}), .q(en_dly)
    );

    assign east_d  = signed'(en_dly[2*AT_IN_W-1:AT_IN_W]);
    assign north_d = signed'(en_dly[AT_IN_W-1:0]);

    logic signed [AT_Z_W-1:0] z_dist, z_az, z_pa;

    hvs_atan2 u_at_dist (.clk(clk), .y_in(signed'({2'b00, root_a})),
                         .x_in(signed'({2'b00, root_b})), .z_out(z_dist));
    hvs_atan2 u_at_az (.clk(clk), .y_in(east_d), .x_in(north_d), .z_out(z_az));
    hvs_atan2 u_at_pa (.clk(clk), .y_in(north_d), .x_in(east_d), .z_out(z_pa));

    // Central angle to distance, and the angles to output units.
    logic signed [48:0]       d1_prod_reg;
    logic signed [AT_Z_W-1:0] d1_az_reg, d1_pa_reg, d2_pa_raw_reg;
    logic signed [48:0]       dist_shift;
    logic [30:0]              d2_dist_reg;
    logic signed [30:0]       d2_az_reg, d2_pa_reg;

    assign dist_shift = (d1_prod_reg + RND_D) >>> DS;

    always_ff @(posedge clk)
    begin
        d1_prod_reg <= 49'(signed'({z_dist, 1'b0})) * signed'(49'(EARTH_RADIUS_KM));
        d1_az_reg   <= z_az;
        d1_pa_reg   <= z_pa;

        if (dist_shift < 0)
            d2_dist_reg <= '0;
        else if (dist_shift > DMAX_49)
            d2_dist_reg <= DIST_MAX;
        else
            d2_dist_reg <= 31'(dist_shift);
        d2_az_reg     <= sat_angle((35'(d1_az_reg) + RND_A) >>> AS);
        d2_pa_reg     <= sat_angle((35'(d1_pa_reg) + RND_A) >>> AS);
        d2_pa_raw_reg <= d1_pa_reg;
    end

    // Sine and cosine of the plane angle for the local offset.
    logic signed [SC_W-1:0] sp, cp;

    hvs_sincos #(.TW(TW)) u_sc_pa (.clk(clk), .theta(TW'(d2_pa_raw_reg)),
                                   .sin_val(sp), .cos_val(cp));

    logic [92:0]        side_dly;
    logic [30:0]        dist_d;
    logic signed [30:0] az_d, pa_d;

    hvs_delay #(.W(93), .D(LSC)) u_dly_side (
        .clk(clk), .rst_n(rst_n), .d({d2_dist_reg, d2_az_reg, d2_pa_reg}), .q(side_dly)
    );

    assign dist_d = side_dly[92:62];
    assign az_d   = signed'(side_dly[61:31]);
    assign pa_d   = signed'(side_dly[30:0]);

    logic signed [63:0] o1_p1_reg, o1_p2_reg;
    logic [30:0]        o1_dist_reg;
    logic signed [30:0] o1_az_reg, o1_pa_reg;
    logic [30:0]        distance_reg;
    logic signed [30:0] azimuth_reg, plane_angle_reg;
    logic signed [31:0] offset_first_reg, offset_second_reg;

    always_ff @(posedge clk)
    begin
        o1_p1_reg   <= 64'(signed'({1'b0, dist_d})) * 64'(sp);
        o1_p2_reg   <= 64'(signed'({1'b0, dist_d})) * 64'(cp);
        o1_dist_reg <= dist_d;
        o1_az_reg   <= az_d;
        o1_pa_reg   <= pa_d;

        distance_reg      <= o1_dist_reg;
        azimuth_reg       <= o1_az_reg;
        plane_angle_reg   <= o1_pa_reg;
        offset_first_reg  <= sat_offset(o1_p1_reg);
        offset_second_reg <= sat_offset(o1_p2_reg);
    end

    // The valid bit of each item travels the full depth of the datapath.
    hvs_delay #(.W(1), .D(LTOT)) u_dly_valid (
        .clk(clk), .rst_n(rst_n), .d(accept), .q(done)
    );

    assign distance      = distance_reg;
    assign azimuth       = azimuth_reg;
    assign plane_angle   = plane_angle_reg;
    assign offset_first  = offset_first_reg;
    assign offset_second = offset_second_reg;

endmodule

### src/hvs_checker.sv
// Port-level checks on the results of the haversine distance core,
// bound to the top level. Depends only on the top level's ports.
module hvs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               done,
    input logic [30:0]        distance,
    input logic signed [30:0] azimuth,
    input logic signed [30:0] plane_angle,
    input logic signed [31:0] offset_first,
    input logic signed [31:0] offset_second
);

    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> distance <= 31'd1311703040)
        else $error("distance above its saturation limit");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (azimuth <= 843314857 && azimuth >= -843314857 &&
                  plane_angle <= 843314857 && plane_angle >= -843314857))
        else $error("angle result outside +/- pi");

    a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (offset_first <= 1311703040 && offset_first >= -1311703040 &&
                  offset_second <= 1311703040 && offset_second >= -1311703040))
        else $error("offset outside its saturation limit");

    a_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (done && distance == 31'd0) |-> (offset_first == 0 && offset_second == 0))
        else $error("nonzero offset for a zero distance");

endmodule

bind haversine_distance_and_bearing_core hvs_checker u_hvs_checker (.*);
